@@ src/tsq_pkg.sv @@
package tsq_pkg;

  // Fixed-point and field widths
  localparam int FRACTION_BITS = 31;
  localparam int SIZE_W        = 32;
  localparam int COORD_W       = 16;
  localparam int IDX_W         = 6;
  localparam int SHARE_W       = FRACTION_BITS + 1;
  localparam int MUL_A_W       = COORD_W + SHARE_W;
  localparam int MUL_B_W       = SHARE_W;
  localparam int PROD_W        = MUL_A_W + MUL_B_W;

  // Input item modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_LAYOUT = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic [SIZE_W-1:0]         child_size;
    logic signed [COORD_W-1:0] rect_left;
    logic signed [COORD_W-1:0] rect_top;
    logic signed [COORD_W-1:0] rect_right;
    logic signed [COORD_W-1:0] rect_bottom;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]          child_index;
    logic signed [COORD_W-1:0] out_left;
    logic signed [COORD_W-1:0] out_top;
    logic signed [COORD_W-1:0] out_right;
    logic signed [COORD_W-1:0] out_bottom;
    logic                      placed;
    logic                      final_rect;
  } out_item_t;

  // One store entry: load index and size
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] size;
  } entry_t;

endpackage

@@ src/tsq_mul.sv @@
// Shift-add multiplier, one multiplier bit per cycle
module tsq_mul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [tsq_pkg::MUL_A_W-1:0]      a,
  input  logic [tsq_pkg::MUL_B_W-1:0]      b,
  output logic                             busy,
  output logic [tsq_pkg::PROD_W-1:0]       prod
);

  localparam int CNT_W = $clog2(tsq_pkg::MUL_B_W + 1);

  logic                          busy_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [tsq_pkg::PROD_W-1:0]    mc_r;
  logic [tsq_pkg::MUL_B_W-1:0]   mp_r;
  logic [tsq_pkg::PROD_W-1:0]    acc_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(tsq_pkg::MUL_B_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) busy_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      mc_r  <= tsq_pkg::PROD_W'(a);
      mp_r  <= b;
    end else if (busy_r) begin
      if (mp_r[0]) acc_r <= acc_r + mc_r;
      mc_r <= mc_r << 1;
      mp_r <= mp_r >> 1;
    end
  end

  assign busy = busy_r;
  assign prod = acc_r;

endmodule

@@ src/tsq_div.sv @@
// Restoring divider giving a Q1.FRACTION_BITS share of num over den
module tsq_div #(
  parameter int SUM_W = 38
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tsq_pkg::SIZE_W-1:0]    num,
  input  logic [SUM_W-1:0]              den,
  output logic                          busy,
  output logic [tsq_pkg::SHARE_W-1:0]   quot
);

  localparam int CNT_W = $clog2(tsq_pkg::FRACTION_BITS + 1);

  logic                          busy_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [SUM_W-1:0]              rem_r;
  logic [SUM_W-1:0]              den_r;
  logic [tsq_pkg::SHARE_W-1:0]   quot_r;
  logic [SUM_W:0]                rem_sh;
  logic                          ge;
  logic                          whole;

  assign whole  = SUM_W'(num) >= den;
  assign rem_sh = {rem_r, 1'b0};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= !whole;
      cnt_r  <= CNT_W'(tsq_pkg::FRACTION_BITS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) busy_r <= 1'b0;
    end
  end

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= SUM_W'(num);
      den_r  <= den;
      quot_r <= whole ? (tsq_pkg::SHARE_W'(1) << tsq_pkg::FRACTION_BITS) : '0;
    end else if (busy_r) begin
      rem_r  <= ge ? SUM_W'(rem_sh - {1'b0, den_r}) : SUM_W'(rem_sh);
      quot_r <= {quot_r[tsq_pkg::SHARE_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quot = quot_r;

endmodule

@@ src/treemap_squarified_layout.sv @@
// Squarified treemap layout.
// Input channel (in_valid/in_stall/in_data): a beat with mode LOAD stores one
// child size (one per cycle, ignored once MAX_CHILDREN are held); a beat with
// mode LAYOUT carries the parent rectangle and starts a layout run over the
// loaded children. in_stall is high for the whole run.
// Output channel (out_valid/out_stall/out_data): one beat per child in
// descending size order, with its load index; final_rect marks the last beat.
// A LAYOUT beat with no children loaded gives no output.
// Timing: a run first insertion-sorts the store in place, then walks the
// sorted store: each range sum reads its children one by one, each candidate
// for a run costs one share division and up to three serial multiplies, and
// each placed child a division and two multiplies.
// The store, read one entry at a time, and the serial divider and multiplier
// set the length of a run.
// Reset clears the loaded count and the output valid flag. A stalled output
// beat holds and the run waits on it; the loaded count is cleared after the run.
module treemap_squarified_layout #(
  parameter int MAX_CHILDREN = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tsq_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tsq_pkg::out_item_t  out_data
);

  localparam int CNT_W  = $clog2(MAX_CHILDREN + 1);
  localparam int ADDR_W = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
  localparam int SUM_W  = tsq_pkg::SIZE_W + $clog2(MAX_CHILDREN);
  localparam int FB     = tsq_pkg::FRACTION_BITS;
  localparam int CW     = tsq_pkg::COORD_W;
  localparam int SW     = tsq_pkg::SHARE_W;

  // state codes
  localparam logic [5:0] ST_IDLE    = 6'd0;
  localparam logic [5:0] ST_SRT_RD  = 6'd1;
  localparam logic [5:0] ST_SRT_LD  = 6'd2;
  localparam logic [5:0] ST_SRT_CRD = 6'd3;
  localparam logic [5:0] ST_SRT_CMP = 6'd4;
  localparam logic [5:0] ST_LAY_TOP = 6'd5;
  localparam logic [5:0] ST_SUM_RD  = 6'd6;
  localparam logic [5:0] ST_SUM_ACC = 6'd7;
  localparam logic [5:0] ST_LAY_TOT = 6'd8;
  localparam logic [5:0] ST_A_DIV   = 6'd9;
  localparam logic [5:0] ST_A_WAIT  = 6'd10;
  localparam logic [5:0] ST_RUN_CHK = 6'd11;
  localparam logic [5:0] ST_Q_DIV   = 6'd12;
  localparam logic [5:0] ST_Q_WAIT  = 6'd13;
  localparam logic [5:0] ST_ASP1    = 6'd14;
  localparam logic [5:0] ST_ASP1_W  = 6'd15;
  localparam logic [5:0] ST_ASP2    = 6'd16;
  localparam logic [5:0] ST_ASP2_W  = 6'd17;
  localparam logic [5:0] ST_ASP3    = 6'd18;
  localparam logic [5:0] ST_ASP3_W  = 6'd19;
  localparam logic [5:0] ST_CUT     = 6'd20;
  localparam logic [5:0] ST_CUT_W   = 6'd21;
  localparam logic [5:0] ST_SL_TOT  = 6'd22;
  localparam logic [5:0] ST_SL_RD   = 6'd23;
  localparam logic [5:0] ST_SL_DIV  = 6'd24;
  localparam logic [5:0] ST_SL_DV_W = 6'd25;
  localparam logic [5:0] ST_SL_M1   = 6'd26;
  localparam logic [5:0] ST_SL_M1_W = 6'd27;
  localparam logic [5:0] ST_SL_M2   = 6'd28;
  localparam logic [5:0] ST_SL_M2_W = 6'd29;
  localparam logic [5:0] ST_SL_EMIT = 6'd30;
  localparam logic [5:0] ST_ZR_RD   = 6'd31;
  localparam logic [5:0] ST_ZR_EMIT = 6'd32;
  localparam logic [5:0] ST_FINISH  = 6'd33;

  // store: load index and size, sorted in place at the start of a run
  tsq_pkg::entry_t mem [MAX_CHILDREN];
  tsq_pkg::entry_t rd_data_r;
  logic            mem_we, mem_re;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  tsq_pkg::entry_t mem_wd;

  logic [5:0]        state_r;
  logic [CNT_W-1:0]  count_r, last_r, i_r, j_r, s_r, mid_r, ptr_r, sum_end_r, sl_end_r;
  tsq_pkg::entry_t   sv_r;
  logic [SUM_W-1:0]  sum_r;
  logic              sum_to_slice_r, final_slice_r;
  logic signed [CW-1:0] lay_l_r, lay_t_r, lay_r_r, lay_b_r;
  logic signed [CW-1:0] sl_l_r, sl_t_r, sl_r_r, sl_b_r;
  logic signed [CW-1:0] c1_r, c2_r;
  logic [SW-1:0]     a_r, b_r, q_r, f_r, acc_r;
  logic [tsq_pkg::MUL_A_W-1:0] p1_r;
  logic [tsq_pkg::PROD_W-1:0]  p2_r;
  logic              out_valid_r;
  tsq_pkg::out_item_t out_data_r;

  // arithmetic units
  logic              div_start, div_busy;
  logic [SW-1:0]     div_quot;
  logic              mul_start, mul_busy;
  logic [tsq_pkg::MUL_A_W-1:0] mul_a;
  logic [tsq_pkg::MUL_B_W-1:0] mul_b;
  logic [tsq_pkg::PROD_W-1:0]  mul_prod;

  // layout and slice geometry
  logic [CW-1:0]     lay_w, lay_h, lay_big, lay_small, sl_w, sl_h, sl_len;
  logic              lay_vert, sl_vert;
  logic signed [CW-1:0] lay_base, sl_base, cut;
  logic              out_free, emit_go, grows, no_grow_q;
  logic [tsq_pkg::PROD_W-1:0] rhs;
  logic              last_range;

  function automatic logic signed [CW-1:0] add_trunc(
    input logic signed [CW-1:0]     base,
    input logic [tsq_pkg::PROD_W-1:0] prod
  );
    logic [CW+1:0] sum;
    logic          frac_nz;
    frac_nz = |prod[FB-1:0];
    sum     = {{2{base[CW-1]}}, base} + {1'b0, prod[FB+CW:FB]};
    if (sum[CW+1] && frac_nz) sum = sum + 1'b1;
    return sum[CW-1:0];
  endfunction

  assign lay_w     = CW'(lay_r_r - lay_l_r);
  assign lay_h     = CW'(lay_b_r - lay_t_r);
  assign lay_vert  = lay_w < lay_h;
  assign lay_big   = lay_vert ? lay_h : lay_w;
  assign lay_small = lay_vert ? lay_w : lay_h;
  assign lay_base  = lay_vert ? lay_t_r : lay_l_r;
  assign sl_w      = CW'(sl_r_r - sl_l_r);
  assign sl_h      = CW'(sl_b_r - sl_t_r);
  assign sl_vert   = sl_w < sl_h;
  assign sl_len    = sl_vert ? sl_h : sl_w;
  assign sl_base   = sl_vert ? sl_t_r : sl_l_r;
  assign cut       = add_trunc(lay_base, mul_prod);
  assign rhs       = tsq_pkg::PROD_W'({mul_prod[tsq_pkg::MUL_A_W-1:0], {FB{1'b0}}});
  assign grows     = p2_r > rhs;
  assign no_grow_q = (lay_big == '0) || (lay_small == '0) || (div_quot == '0);
  assign last_range = (s_r == last_r) || ((CNT_W+1)'(s_r) + 1'b1 == (CNT_W+1)'(last_r));

  assign out_free = !out_valid_r || !out_stall;
  assign emit_go  = ((state_r == ST_SL_EMIT) || (state_r == ST_ZR_EMIT)) && out_free;

  // arithmetic unit starts and operands
  assign div_start = (state_r == ST_A_DIV) || (state_r == ST_Q_DIV) || (state_r == ST_SL_DIV);
  assign mul_start = (state_r == ST_ASP1) || (state_r == ST_ASP2) || (state_r == ST_ASP3) ||
                     (state_r == ST_CUT) || (state_r == ST_SL_M1) || (state_r == ST_SL_M2);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_ASP1: begin
        mul_a = tsq_pkg::MUL_A_W'(b_r);
        mul_b = tsq_pkg::MUL_B_W'(lay_big);
      end
      ST_ASP2: begin
        mul_a = p1_r;
        mul_b = tsq_pkg::MUL_B_W'(b_r + q_r);
      end
      ST_ASP3: begin
        mul_a = tsq_pkg::MUL_A_W'(a_r);
        mul_b = tsq_pkg::MUL_B_W'(lay_small);
      end
      ST_CUT: begin
        mul_a = tsq_pkg::MUL_A_W'(b_r);
        mul_b = tsq_pkg::MUL_B_W'(lay_big);
      end
      ST_SL_M1: begin
        mul_a = tsq_pkg::MUL_A_W'(acc_r);
        mul_b = tsq_pkg::MUL_B_W'(sl_len);
      end
      ST_SL_M2: begin
        mul_a = tsq_pkg::MUL_A_W'(f_r);
        mul_b = tsq_pkg::MUL_B_W'(sl_len);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  tsq_div #(.SUM_W(SUM_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (rd_data_r.size),
    .den   (sum_r),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  tsq_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .prod  (mul_prod)
  );

  // store port control
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = '0;
    mem_ra = '0;
    mem_wd = sv_r;
    unique case (state_r)
      ST_IDLE: begin
        mem_we = in_valid && (in_data.mode == tsq_pkg::MODE_LOAD) &&
                 (count_r < CNT_W'(MAX_CHILDREN));
        mem_wa = count_r[ADDR_W-1:0];
        mem_wd = '{idx: tsq_pkg::IDX_W'(count_r), size: in_data.child_size};
      end
      ST_SRT_RD: begin
        mem_re = 1'b1;
        mem_ra = i_r[ADDR_W-1:0];
      end
      ST_SRT_CRD: begin
        if (j_r == '0) begin
          mem_we = 1'b1;
          mem_wa = '0;
        end else begin
          mem_re = 1'b1;
          mem_ra = ADDR_W'(j_r - 1'b1);
        end
      end
      ST_SRT_CMP: begin
        mem_we = 1'b1;
        mem_wa = j_r[ADDR_W-1:0];
        mem_wd = (rd_data_r.size < sv_r.size) ? rd_data_r : sv_r;
      end
      ST_SUM_RD: begin
        mem_re = 1'b1;
        mem_ra = ptr_r[ADDR_W-1:0];
      end
      ST_LAY_TOT: begin
        mem_re = 1'b1;
        mem_ra = s_r[ADDR_W-1:0];
      end
      ST_RUN_CHK: begin
        mem_re = (mid_r != last_r);
        mem_ra = ADDR_W'(mid_r + 1'b1);
      end
      ST_SL_RD, ST_ZR_RD: begin
        mem_re = 1'b1;
        mem_ra = i_r[ADDR_W-1:0];
      end
      default: begin
        mem_we = 1'b0;
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_r <= mem[mem_ra];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data_r.child_index <= rd_data_r.idx;
      out_data_r.final_rect  <= (i_r == last_r);
      if (state_r == ST_ZR_EMIT) begin
        out_data_r.out_left   <= '0;
        out_data_r.out_top    <= '0;
        out_data_r.out_right  <= '0;
        out_data_r.out_bottom <= '0;
        out_data_r.placed     <= 1'b0;
      end else begin
        out_data_r.out_left   <= sl_vert ? sl_l_r : c1_r;
        out_data_r.out_top    <= sl_vert ? c1_r : sl_t_r;
        out_data_r.out_right  <= sl_vert ? sl_r_r : c2_r;
        out_data_r.out_bottom <= sl_vert ? c2_r : sl_b_r;
        out_data_r.placed     <= 1'b1;
      end
    end
  end

  // run sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_data.mode == tsq_pkg::MODE_LOAD) begin
              if (count_r < CNT_W'(MAX_CHILDREN)) count_r <= count_r + 1'b1;
            end else if (count_r != '0) begin
              lay_l_r <= in_data.rect_left;
              lay_t_r <= in_data.rect_top;
              lay_r_r <= ($signed(in_data.rect_right) < $signed(in_data.rect_left)) ?
                         in_data.rect_left : in_data.rect_right;
              lay_b_r <= ($signed(in_data.rect_bottom) < $signed(in_data.rect_top)) ?
                         in_data.rect_top : in_data.rect_bottom;
              last_r  <= count_r - 1'b1;
              s_r     <= '0;
              i_r     <= CNT_W'(1);
              state_r <= (count_r == CNT_W'(1)) ? ST_LAY_TOP : ST_SRT_RD;
            end
          end
        end
        // insertion sort, descending, ties keep load order
        ST_SRT_RD: state_r <= ST_SRT_LD;
        ST_SRT_LD: begin
          sv_r    <= rd_data_r;
          j_r     <= i_r;
          state_r <= ST_SRT_CRD;
        end
        ST_SRT_CRD: begin
          if (j_r == '0) begin
            i_r     <= i_r + 1'b1;
            state_r <= (i_r == last_r) ? ST_LAY_TOP : ST_SRT_RD;
          end else begin
            state_r <= ST_SRT_CMP;
          end
        end
        ST_SRT_CMP: begin
          if (rd_data_r.size < sv_r.size) begin
            j_r     <= j_r - 1'b1;
            state_r <= ST_SRT_CRD;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= (i_r == last_r) ? ST_LAY_TOP : ST_SRT_RD;
          end
        end
        // layout loop head: sum the remaining range
        ST_LAY_TOP: begin
          if (s_r > last_r) begin
            state_r <= ST_FINISH;
          end else begin
            ptr_r          <= s_r;
            sum_end_r      <= last_r;
            sum_r          <= '0;
            sum_to_slice_r <= 1'b0;
            state_r        <= ST_SUM_RD;
          end
        end
        ST_SUM_RD: state_r <= ST_SUM_ACC;
        ST_SUM_ACC: begin
          sum_r <= sum_r + SUM_W'(rd_data_r.size);
          if (ptr_r == sum_end_r) begin
            state_r <= sum_to_slice_r ? ST_SL_TOT : ST_LAY_TOT;
          end else begin
            ptr_r   <= ptr_r + 1'b1;
            state_r <= ST_SUM_RD;
          end
        end
        ST_LAY_TOT: begin
          if (sum_r == '0) begin
            i_r     <= s_r;
            state_r <= ST_ZR_RD;
          end else if (last_range) begin
            final_slice_r <= 1'b1;
            sl_l_r        <= lay_l_r;
            sl_t_r        <= lay_t_r;
            sl_r_r        <= lay_r_r;
            sl_b_r        <= lay_b_r;
            sl_end_r      <= last_r;
            state_r       <= ST_SL_TOT;
          end else begin
            state_r <= ST_A_DIV;
          end
        end
        // grow the run while the aspect ratio does not worsen
        ST_A_DIV: state_r <= ST_A_WAIT;
        ST_A_WAIT: begin
          if (!div_busy) begin
            a_r     <= div_quot;
            b_r     <= div_quot;
            mid_r   <= s_r;
            state_r <= ST_RUN_CHK;
          end
        end
        ST_RUN_CHK: state_r <= (mid_r == last_r) ? ST_CUT : ST_Q_DIV;
        ST_Q_DIV: state_r <= ST_Q_WAIT;
        ST_Q_WAIT: begin
          if (!div_busy) begin
            q_r <= div_quot;
            if (no_grow_q) begin
              b_r     <= b_r + div_quot;
              mid_r   <= mid_r + 1'b1;
              state_r <= ST_RUN_CHK;
            end else begin
              state_r <= ST_ASP1;
            end
          end
        end
        ST_ASP1: state_r <= ST_ASP1_W;
        ST_ASP1_W: begin
          if (!mul_busy) begin
            p1_r    <= mul_prod[tsq_pkg::MUL_A_W-1:0];
            state_r <= ST_ASP2;
          end
        end
        ST_ASP2: state_r <= ST_ASP2_W;
        ST_ASP2_W: begin
          if (!mul_busy) begin
            p2_r    <= mul_prod;
            state_r <= ST_ASP3;
          end
        end
        ST_ASP3: state_r <= ST_ASP3_W;
        ST_ASP3_W: begin
          if (!mul_busy) begin
            if (grows) begin
              state_r <= ST_CUT;
            end else begin
              b_r     <= b_r + q_r;
              mid_r   <= mid_r + 1'b1;
              state_r <= ST_RUN_CHK;
            end
          end
        end
        // cut the run off the short side
        ST_CUT: state_r <= ST_CUT_W;
        ST_CUT_W: begin
          if (!mul_busy) begin
            sl_l_r         <= lay_l_r;
            sl_t_r         <= lay_t_r;
            sl_r_r         <= lay_vert ? lay_r_r : cut;
            sl_b_r         <= lay_vert ? cut : lay_b_r;
            if (lay_vert) lay_t_r <= cut;
            else          lay_l_r <= cut;
            final_slice_r  <= 1'b0;
            sl_end_r       <= mid_r;
            ptr_r          <= s_r;
            sum_end_r      <= mid_r;
            sum_r          <= '0;
            sum_to_slice_r <= 1'b1;
            state_r        <= ST_SUM_RD;
          end
        end
        // slice a range along its long side
        ST_SL_TOT: begin
          i_r     <= s_r;
          acc_r   <= '0;
          state_r <= (sum_r == '0) ? ST_ZR_RD : ST_SL_RD;
        end
        ST_SL_RD:  state_r <= ST_SL_DIV;
        ST_SL_DIV: state_r <= ST_SL_DV_W;
        ST_SL_DV_W: begin
          if (!div_busy) begin
            f_r     <= div_quot;
            state_r <= ST_SL_M1;
          end
        end
        ST_SL_M1: state_r <= ST_SL_M1_W;
        ST_SL_M1_W: begin
          if (!mul_busy) begin
            c1_r    <= add_trunc(sl_base, mul_prod);
            state_r <= ST_SL_M2;
          end
        end
        ST_SL_M2: state_r <= ST_SL_M2_W;
        ST_SL_M2_W: begin
          if (!mul_busy) begin
            c2_r    <= add_trunc(c1_r, mul_prod);
            state_r <= ST_SL_EMIT;
          end
        end
        ST_SL_EMIT: begin
          if (out_free) begin
            acc_r <= acc_r + f_r;
            if (i_r == sl_end_r) begin
              s_r     <= sl_end_r + 1'b1;
              state_r <= final_slice_r ? ST_FINISH : ST_LAY_TOP;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= ST_SL_RD;
            end
          end
        end
        // zero-sum tail: unplaced beats
        ST_ZR_RD: state_r <= ST_ZR_EMIT;
        ST_ZR_EMIT: begin
          if (out_free) begin
            if (i_r == last_r) begin
              state_r <= ST_FINISH;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= ST_ZR_RD;
            end
          end
        end
        ST_FINISH: begin
          count_r <= '0;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/tsq_chk.sv @@
// Port-level checks for the layout block
module tsq_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input tsq_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input tsq_pkg::out_item_t out_data
);

  // a stalled input beat stays
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input beat changed");

  // a stalled beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // no input is taken in the middle of a run
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.final_rect |-> in_stall)
    else $error("input taken while a run is still emitting");

  // unplaced beats carry an empty rectangle
  a_unplaced_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.placed |->
      out_data.out_left == '0 && out_data.out_top == '0 &&
      out_data.out_right == '0 && out_data.out_bottom == '0)
    else $error("unplaced beat with nonzero rectangle");

  // placed beats are never inverted
  a_placed_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.placed |->
      $signed(out_data.out_left) <= $signed(out_data.out_right) &&
      $signed(out_data.out_top) <= $signed(out_data.out_bottom))
    else $error("placed beat with inverted rectangle");

endmodule

bind treemap_squarified_layout tsq_chk u_tsq_chk (.*);

@@ tb/sv/tb_treemap_squarified_layout.sv @@
module tb_treemap_squarified_layout;

  localparam int MAX_KIDS = 64;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  tsq_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  tsq_pkg::out_item_t out_data;

  treemap_squarified_layout #(.MAX_CHILDREN(MAX_KIDS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predictor state
  logic [31:0] loaded_sizes[MAX_KIDS];
  int          loaded_n;
  logic [31:0] sorted_size[MAX_KIDS];
  logic [5:0]  sorted_idx[MAX_KIDS];
  int          pl_l[MAX_KIDS], pl_t[MAX_KIDS], pl_r[MAX_KIDS], pl_b[MAX_KIDS];
  bit          pl_p[MAX_KIDS];

  tsq_pkg::out_item_t expected_rects[$];
  int          errors;
  int          send_idle_pct;
  int          recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Q1.31 share of a total, restoring division
  function automatic logic [63:0] frac_share(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] q;
    rem = num;
    q = 0;
    if (den == 0) return 0;
    if (num >= den) return 64'd1 << tsq_pkg::FRACTION_BITS;
    for (int i = 0; i < tsq_pkg::FRACTION_BITS; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // base + len*f, truncated toward zero
  function automatic int coord_at(int base, logic [31:0] len, logic [63:0] f);
    logic [95:0] prod;
    int s;
    prod = len * f;
    s = base + int'(prod >> tsq_pkg::FRACTION_BITS);
    if (s < 0 && prod[tsq_pkg::FRACTION_BITS-1:0] != 0) s = s + 1;
    return s;
  endfunction

  function automatic bit ratio_worse(logic [31:0] big, logic [31:0] sml, logic [63:0] a,
                                     logic [63:0] b0, logic [63:0] b1);
    logic [159:0] lhs;
    logic [159:0] rhs;
    if (big == 0 || sml == 0 || b1 <= b0) return 1'b0;
    lhs = big * b0 * b1;
    rhs = (sml * a) << tsq_pkg::FRACTION_BITS;
    return lhs > rhs;
  endfunction

  function automatic logic [63:0] span_total(int s, int e);
    logic [63:0] t;
    t = 0;
    for (int i = s; i <= e; i++) t += sorted_size[i];
    return t;
  endfunction

  function automatic void slice_span(int s, int e, int lf, int tp, int rt, int bt);
    logic [63:0] total;
    logic [63:0] acc;
    logic [63:0] f;
    logic [31:0] w;
    logic [31:0] h;
    bit vert;
    total = span_total(s, e);
    acc = 0;
    if (total == 0) return;
    if (rt < lf) rt = lf;
    if (bt < tp) bt = tp;
    w = rt - lf;
    h = bt - tp;
    vert = w < h;
    for (int i = s; i <= e; i++) begin
      f = frac_share(sorted_size[i], total);
      if (vert) begin
        pl_l[i] = lf;
        pl_r[i] = rt;
        pl_t[i] = coord_at(tp, h, acc);
        pl_b[i] = coord_at(pl_t[i], h, f);
      end else begin
        pl_t[i] = tp;
        pl_b[i] = bt;
        pl_l[i] = coord_at(lf, w, acc);
        pl_r[i] = coord_at(pl_l[i], w, f);
      end
      pl_p[i] = 1'b1;
      acc += f;
    end
  endfunction

  // Squarified layout over the sorted children, iterative
  function automatic void squarify(int n, int lf, int tp, int rt, int bt);
    int s;
    int e;
    int mid;
    int cut;
    logic [63:0] total;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] q;
    logic [31:0] w;
    logic [31:0] h;
    bit stop;
    s = 0;
    e = n - 1;
    while (s <= e) begin
      if (e - s < 2) begin
        slice_span(s, e, lf, tp, rt, bt);
        return;
      end
      total = span_total(s, e);
      if (total == 0) return;
      w = rt - lf;
      h = bt - tp;
      a = frac_share(sorted_size[s], total);
      b = a;
      mid = s;
      while (mid < e) begin
        q = frac_share(sorted_size[mid+1], total);
        stop = (w < h) ? ratio_worse(h, w, a, b, b + q) : ratio_worse(w, h, a, b, b + q);
        if (stop) break;
        b += q;
        mid++;
      end
      if (w < h) begin
        cut = coord_at(tp, h, b);
        slice_span(s, mid, lf, tp, rt, cut);
        tp = cut;
      end else begin
        cut = coord_at(lf, w, b);
        slice_span(s, mid, lf, tp, cut, bt);
        lf = cut;
      end
      s = mid + 1;
    end
  endfunction

  function automatic void predict_beat(tsq_pkg::in_item_t it);
    int n;
    int j;
    int lf, tp, rt, bt;
    tsq_pkg::out_item_t o;
    n = loaded_n;
    if (it.mode == tsq_pkg::MODE_LOAD) begin
      if (loaded_n < MAX_KIDS) begin
        loaded_sizes[loaded_n] = it.child_size;
        loaded_n++;
      end
      return;
    end
    if (n == 0) return;
    lf = it.rect_left;
    tp = it.rect_top;
    rt = it.rect_right;
    bt = it.rect_bottom;
    if (rt < lf) rt = lf;
    if (bt < tp) bt = tp;
    // stable descending insertion sort
    for (int i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && sorted_size[j-1] < loaded_sizes[i]) begin
        sorted_size[j] = sorted_size[j-1];
        sorted_idx[j] = sorted_idx[j-1];
        j--;
      end
      sorted_size[j] = loaded_sizes[i];
      sorted_idx[j] = 6'(i);
    end
    for (int i = 0; i < n; i++) begin
      pl_l[i] = 0; pl_t[i] = 0; pl_r[i] = 0; pl_b[i] = 0; pl_p[i] = 0;
    end
    squarify(n, lf, tp, rt, bt);
    for (int i = 0; i < n; i++) begin
      o.child_index = sorted_idx[i];
      o.out_left = 16'(pl_l[i]);
      o.out_top = 16'(pl_t[i]);
      o.out_right = 16'(pl_r[i]);
      o.out_bottom = 16'(pl_b[i]);
      o.placed = pl_p[i];
      o.final_rect = (i == n - 1);
      expected_rects.push_back(o);
    end
    loaded_n = 0;
  endfunction

  // Result checker and receiver stall
  always @(posedge clk) begin
    tsq_pkg::out_item_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rects.size() == 0) begin
          $display("%0t unexpected rect: expected none, actual %p", $time, out_data);
          errors++;
        end else begin
          exp_r = expected_rects.pop_front();
          if (out_data.child_index !== exp_r.child_index)
            begin $display("%0t child_index: expected %0d, actual %0d", $time,
              exp_r.child_index, out_data.child_index); errors++; end
          if (out_data.out_left !== exp_r.out_left)
            begin $display("%0t out_left: expected %0d, actual %0d", $time,
              exp_r.out_left, out_data.out_left); errors++; end
          if (out_data.out_top !== exp_r.out_top)
            begin $display("%0t out_top: expected %0d, actual %0d", $time,
              exp_r.out_top, out_data.out_top); errors++; end
          if (out_data.out_right !== exp_r.out_right)
            begin $display("%0t out_right: expected %0d, actual %0d", $time,
              exp_r.out_right, out_data.out_right); errors++; end
          if (out_data.out_bottom !== exp_r.out_bottom)
            begin $display("%0t out_bottom: expected %0d, actual %0d", $time,
              exp_r.out_bottom, out_data.out_bottom); errors++; end
          if (out_data.placed !== exp_r.placed)
            begin $display("%0t placed: expected %0d, actual %0d", $time,
              exp_r.placed, out_data.placed); errors++; end
          if (out_data.final_rect !== exp_r.final_rect)
            begin $display("%0t final_rect: expected %0d, actual %0d", $time,
              exp_r.final_rect, out_data.final_rect); errors++; end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Send one beat, with random idle cycles before it; valid stays up after
  // acceptance until the next beat or an idle cycle takes over
  task automatic send_beat(tsq_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(it);
  endtask

  task automatic load_size(logic [31:0] sz);
    tsq_pkg::in_item_t it;
    it = '0;
    it.mode = tsq_pkg::MODE_LOAD;
    it.child_size = sz;
    send_beat(it);
  endtask

  task automatic run_layout(logic [15:0] lf, logic [15:0] tp, logic [15:0] rt,
                            logic [15:0] bt);
    tsq_pkg::in_item_t it;
    it = '0;
    it.mode = tsq_pkg::MODE_LAYOUT;
    it.rect_left = lf;
    it.rect_top = tp;
    it.rect_right = rt;
    it.rect_bottom = bt;
    send_beat(it);
  endtask

  // Sender goes quiet until every expected result has come
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rects.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_size();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(9);
      3: return $urandom_range(1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(400)) - 200);
    endcase
  endfunction

  // Extremes, zero sums, inverted and degenerate rectangles, empty layout
  task automatic test_directed();
    run_layout(16'sd0, 16'sd0, 16'sd100, 16'sd100);
    load_size(32'hFFFF_FFFF);
    run_layout(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    load_size(32'd6); load_size(32'd6); load_size(32'd4); load_size(32'd3);
    load_size(32'd2); load_size(32'd2); load_size(32'd1);
    run_layout(16'sd0, 16'sd0, 16'sd600, 16'sd400);
    load_size(32'd0); load_size(32'd0); load_size(32'd0);
    run_layout(16'sd10, 16'sd10, 16'sd50, 16'sd90);
    load_size(32'd5); load_size(32'd0); load_size(32'hFFFF_FFFF); load_size(32'd7);
    run_layout(16'sd100, 16'sd100, -16'sd100, -16'sd50);
    load_size(32'd3); load_size(32'd3); load_size(32'd3);
    run_layout(-16'sd20, 16'sd5, -16'sd20, 16'sd80);
    drain_results();
  endtask

  // Fill past the store limit so overflow loads are dropped
  task automatic test_store_full();
    for (int i = 0; i < MAX_KIDS + 3; i++) load_size($urandom_range(1, 50));
    run_layout(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    drain_results();
  endtask

  // Batches of random sizes and rectangles, some empty, zero-sized or inverted
  task automatic test_random(int loads);
    int n;
    int sent;
    sent = 0;
    while (sent < loads) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 6);
      for (int i = 0; i < n; i++) load_size(rand_size());
      if ($urandom_range(3) == 0) drain_results();
      run_layout(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      sent += n + 1;
    end
    drain_results();
  endtask

  initial begin
    errors = 0;
    loaded_n = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 7;
    recv_idle_pct = 72;
    test_directed();
    test_random(20);
    send_idle_pct = 72;
    recv_idle_pct = 7;
    test_store_full();
    test_random(15);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(15);
    drain_results();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
